// ----- src/ubtq_pkg.sv -----
`timescale 1ns / 1ps
package ubtq_pkg;
   localparam int RX_DEPTH     = 128;
   localparam int TX_DEPTH     = 256;
   localparam int WAITER_DEPTH = 16;
   localparam int CHUNK_MAX    = 8;
   localparam int ID_BITS      = 8;
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int WT_AW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int RX_FW = $clog2(RX_DEPTH + 1);
   localparam int TX_FW = $clog2(TX_DEPTH + 1);
   localparam int WT_FW = $clog2(WAITER_DEPTH + 1);
   localparam int CH_CW = $clog2(CHUNK_MAX + 1);

   typedef enum logic [2:0] {
      OP_GET = 3'd0, OP_POLL = 3'd1, OP_PUT = 3'd2, OP_RXB = 3'd3,
      OP_TXRDY = 3'd4, OP_CHUNK = 3'd5, OP_BAD6 = 3'd6, OP_BAD7 = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_BLOCK = 2'd2, ST_ERR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DST_REQ = 2'd0, DST_WAITER = 2'd1, DST_TX = 2'd2
   } dest_type;

   localparam int CSR_RX_EN = 0;
   localparam int CSR_TX_EN = 1;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHUNK, S_WAKE, S_REPLY
   } state_type;
endpackage

// ----- src/uart_buffered_terminal_queues.sv -----
`timescale 1ns / 1ps
// the request is decided in the read state and its result shown in the reply state; a chunk
// write first passes through the chunk state, as the tx memory has a single write port
// busy is high from the accepting edge until the last result, if any, has been shown
// reset: synchronous, active high; pointers, fill counts and parked flag clear, both
// enables set; memories are not cleared. results cannot be stalled by the receiver
module uart_buffered_terminal_queues (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_client_id,
   input  logic [7:0]  req_data_byte,
   input  logic [3:0]  req_chunk_length,
   input  logic [63:0] req_chunk_bytes,
   output logic        rsp_valid,
   output logic [1:0]  rsp_destination,
   output logic [7:0]  rsp_target_id,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_data
);
   import ubtq_pkg::*;

   state_type state_ff, state_in;
   logic rx_en_ff, tx_en_ff, parked_ff, parked_in;
   logic [RX_AW-1:0] rx_rp_ff, rx_rp_in, rx_wp_ff, rx_wp_in;
   logic [RX_FW-1:0] rx_fill_ff, rx_fill_in;
   logic [TX_AW-1:0] tx_rp_ff, tx_rp_in, tx_wp_ff, tx_wp_in;
   logic [TX_FW-1:0] tx_fill_ff, tx_fill_in;
   logic [WT_AW-1:0] wt_rp_ff, wt_rp_in, wt_wp_ff, wt_wp_in;
   logic [WT_FW-1:0] wt_fill_ff, wt_fill_in;

   op_type op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [7:0] data_ff, data_in;
   logic [CH_CW-1:0] len_ff, len_in, cnt_ff, cnt_in;
   logic [63:0] chunk_ff, chunk_in;
   logic wake_ff, wake_in;
   logic [1:0] stat_ff, stat_in;
   logic byte_sel_ff, byte_sel_in; // reply carries memory byte

   logic rx_we, tx_we, wt_we;
   logic [7:0] rx_wd, tx_wd, rx_rd, tx_rd;
   logic [ID_BITS-1:0] wt_rd;
   logic [7:0] tx_rd_hold_ff, tx_rd_hold_in;
   logic tx_byp_ff, tx_byp_in;
   logic [7:0] tx_byp_data_ff, tx_byp_data_in;

   logic [TX_FW-1:0] tx_free;
   logic len_bad;

   ubtq_fifo_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx (
      .clock(clock), .wr_en(rx_we), .wr_addr(rx_wp_ff), .wr_data(rx_wd),
      .rd_addr(rx_rp_ff), .rd_data(rx_rd));
   ubtq_fifo_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx (
      .clock(clock), .wr_en(tx_we), .wr_addr(tx_wp_ff), .wr_data(tx_wd),
      .rd_addr(tx_rp_ff), .rd_data(tx_rd));
   ubtq_fifo_ram #(.DEPTH(1 << WT_AW), .WIDTH(ID_BITS)) u_wt (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_wp_ff), .wr_data(id_ff),
      .rd_addr(wt_rp_ff), .rd_data(wt_rd));

   function automatic logic [RX_AW-1:0] rx_nx(input logic [RX_AW-1:0] p);
      rx_nx = (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction
   function automatic logic [TX_AW-1:0] tx_nx(input logic [TX_AW-1:0] p);
      tx_nx = (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction
   function automatic logic [WT_AW-1:0] wt_nx(input logic [WT_AW-1:0] p);
      wt_nx = (p == WT_AW'(WAITER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign tx_free = TX_FW'(TX_DEPTH) - tx_fill_ff;
   assign len_bad = (len_ff == '0) || (len_ff > CH_CW'(CHUNK_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rx_en_ff <= 1'b1; tx_en_ff <= 1'b1; parked_ff <= 1'b0;
         rx_rp_ff <= '0; rx_wp_ff <= '0; rx_fill_ff <= '0;
         tx_rp_ff <= '0; tx_wp_ff <= '0; tx_fill_ff <= '0;
         wt_rp_ff <= '0; wt_wp_ff <= '0; wt_fill_ff <= '0;
      end else begin
         state_ff <= state_in; parked_ff <= parked_in;
         rx_rp_ff <= rx_rp_in; rx_wp_ff <= rx_wp_in; rx_fill_ff <= rx_fill_in;
         tx_rp_ff <= tx_rp_in; tx_wp_ff <= tx_wp_in; tx_fill_ff <= tx_fill_in;
         wt_rp_ff <= wt_rp_in; wt_wp_ff <= wt_wp_in; wt_fill_ff <= wt_fill_in;
         if (csr_write && csr_index == 1'(CSR_RX_EN)) rx_en_ff <= csr_data[0];
         if (csr_write && csr_index == 1'(CSR_TX_EN)) tx_en_ff <= csr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; id_ff <= id_in; data_ff <= data_in; len_ff <= len_in;
      cnt_ff <= cnt_in; chunk_ff <= chunk_in; wake_ff <= wake_in;
      stat_ff <= stat_in; byte_sel_ff <= byte_sel_in; tx_rd_hold_ff <= tx_rd_hold_in;
      tx_byp_ff <= tx_byp_in; tx_byp_data_ff <= tx_byp_data_in;
   end

   always_comb begin
      state_in = state_ff; parked_in = parked_ff;
      rx_rp_in = rx_rp_ff; rx_wp_in = rx_wp_ff; rx_fill_in = rx_fill_ff;
      tx_rp_in = tx_rp_ff; tx_wp_in = tx_wp_ff; tx_fill_in = tx_fill_ff;
      wt_rp_in = wt_rp_ff; wt_wp_in = wt_wp_ff; wt_fill_in = wt_fill_ff;
      op_in = op_ff; id_in = id_ff; data_in = data_ff; len_in = len_ff;
      cnt_in = cnt_ff; chunk_in = chunk_ff; wake_in = wake_ff;
      stat_in = stat_ff; byte_sel_in = byte_sel_ff; tx_rd_hold_in = tx_rd_hold_ff;
      rx_we = 1'b0; tx_we = 1'b0; wt_we = 1'b0;
      rx_wd = data_ff; tx_wd = data_ff;
      busy = (state_ff != S_IDLE);
      rsp_valid = 1'b0; rsp_destination = DST_REQ; rsp_target_id = 8'(id_ff);
      rsp_status = stat_ff; rsp_reply_byte = '0; rsp_last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op_type'(req_opcode);
               id_in = req_client_id[ID_BITS-1:0];
               data_in = req_data_byte;
               len_in = CH_CW'(req_chunk_length);
               if (req_chunk_length > 4'(CHUNK_MAX)) len_in = '0;
               chunk_in = req_chunk_bytes;
               cnt_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // decide; memory reads at current read pointers land next cycle
            wake_in = 1'b0; byte_sel_in = 1'b0; stat_in = ST_OK;
            state_in = S_REPLY;
            unique case (op_ff)
               OP_GET, OP_POLL: begin
                  if (rx_fill_ff != '0) begin
                     byte_sel_in = 1'b1;
                     rx_rp_in = rx_nx(rx_rp_ff); rx_fill_in = rx_fill_ff - 1'b1;
                  end else if (op_ff == OP_POLL) stat_in = ST_EMPTY;
                  else if (!rx_en_ff || wt_fill_ff >= WT_FW'(WAITER_DEPTH)) stat_in = ST_ERR;
                  else begin
                     wt_we = 1'b1; wt_wp_in = wt_nx(wt_wp_ff);
                     wt_fill_in = wt_fill_ff + 1'b1; state_in = S_IDLE;
                  end
               end
               OP_PUT: begin
                  if (!tx_en_ff || tx_fill_ff >= TX_FW'(TX_DEPTH)) stat_in = ST_ERR;
                  else begin
                     tx_we = 1'b1; tx_wp_in = tx_nx(tx_wp_ff);
                     tx_fill_in = tx_fill_ff + 1'b1;
                     wake_in = parked_ff;
                     if (parked_ff) state_in = S_WAKE;
                  end
               end
               OP_RXB: begin
                  if (!rx_en_ff) stat_in = ST_ERR;
                  else if (wt_fill_ff != '0) begin
                     wt_rp_in = wt_nx(wt_rp_ff); wt_fill_in = wt_fill_ff - 1'b1;
                     wake_in = 1'b1; state_in = S_WAKE;
                  end else if (rx_fill_ff >= RX_FW'(RX_DEPTH)) stat_in = ST_ERR;
                  else begin
                     rx_we = 1'b1; rx_wp_in = rx_nx(rx_wp_ff);
                     rx_fill_in = rx_fill_ff + 1'b1;
                  end
               end
               OP_TXRDY: begin
                  if (!tx_en_ff || parked_ff) stat_in = ST_ERR;
                  else if (tx_fill_ff != '0) begin
                     byte_sel_in = 1'b1;
                     tx_rp_in = tx_nx(tx_rp_ff); tx_fill_in = tx_fill_ff - 1'b1;
                  end else begin
                     parked_in = 1'b1; state_in = S_IDLE;
                  end
               end
               OP_CHUNK: begin
                  if (len_bad || !tx_en_ff) stat_in = ST_ERR;
                  else if (TX_FW'(len_ff) > tx_free) stat_in = ST_BLOCK;
                  else begin
                     wake_in = parked_ff; state_in = S_CHUNK;
                  end
               end
               default: stat_in = ST_ERR;
            endcase
         end
         S_CHUNK: begin
            tx_we = 1'b1;
            tx_wd = chunk_ff[7:0];
            chunk_in = chunk_ff >> 8;
            tx_wp_in = tx_nx(tx_wp_ff); tx_fill_in = tx_fill_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == len_ff) state_in = wake_ff ? S_WAKE : S_REPLY;
         end
         S_WAKE: begin
            // tx read data at the read pointer, or the byte written at that address last edge
            if (op_ff == OP_RXB) begin
               rsp_valid = 1'b1; rsp_destination = DST_WAITER;
               rsp_target_id = 8'(wt_rd); rsp_reply_byte = data_ff; rsp_last = 1'b0;
               state_in = S_REPLY;
            end else begin
               rsp_valid = 1'b1; rsp_destination = DST_TX; rsp_target_id = '0;
               rsp_status = ST_OK; rsp_reply_byte = tx_byp_ff ? tx_byp_data_ff : tx_rd;
               rsp_last = 1'b0;
               tx_rp_in = tx_nx(tx_rp_ff); tx_fill_in = tx_fill_ff - 1'b1;
               parked_in = 1'b0; state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            rsp_valid = 1'b1;
            if (byte_sel_ff)
               rsp_reply_byte = (op_ff == OP_TXRDY) ? tx_rd_hold_ff : rx_rd;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // tx memory output changes after the read pointer moves; capture in read stage
      if (state_ff == S_READ) tx_rd_hold_in = tx_rd;
      // write and read of the same tx entry at one edge
      tx_byp_in = tx_we && (tx_wp_ff == tx_rp_ff);
      tx_byp_data_in = tx_wd;
   end
endmodule

// ----- src/ubtq_fifo_ram.sv -----
`timescale 1ns / 1ps
module ubtq_fifo_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/ubtq_checker.sv -----
`timescale 1ns / 1ps
module ubtq_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_destination,
   input logic       rsp_last
);
   import ubtq_pkg::*;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_nonlast_followed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_last) else $error("missing final beat");
   a_last_to_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_destination == DST_REQ) else $error("bad final destination");
endmodule

bind uart_buffered_terminal_queues ubtq_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_destination(rsp_destination), .rsp_last(rsp_last));
